// ----- rtl/core/ppm_pkg.sv -----
// Shared types and constants for the perspective projection matrix block.
// Depends on nothing; used by ppm_cordic, ppm_div and the top level.
package ppm_pkg;

    localparam int FRAC_BITS       = 16;
    localparam int FOV_W           = 24;
    localparam int ASPECT_W        = 31;
    localparam int CORDIC_STEPS    = 30;
    localparam int CORDIC_W        = 34;
    localparam int CORDIC_GAIN_Q30 = 652032874;
    localparam int PI_OVER_360_Q32 = 37480660;
    localparam int DIV_NUM_W       = 64;
    localparam int DIV_DEN_W       = 33;
    localparam int DIV_Q_W         = DIV_NUM_W + 1;
    localparam int DIV_LAT         = DIV_NUM_W + 2;

    typedef logic signed [CORDIC_W-1:0] cword_t;

    localparam cword_t ATAN_Q30 [CORDIC_STEPS] = '{
        34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133525159,
        34'sd67021687, 34'sd33543516, 34'sd16775851, 34'sd8388437,
        34'sd4194283, 34'sd2097149, 34'sd1048576, 34'sd524288, 34'sd262144,
        34'sd131072, 34'sd65536, 34'sd32768, 34'sd16384, 34'sd8192,
        34'sd4096, 34'sd2048, 34'sd1024, 34'sd512, 34'sd256, 34'sd128,
        34'sd64, 34'sd32, 34'sd16, 34'sd8, 34'sd4, 34'sd2
    };

    typedef struct packed {
        logic                       opcode;
        logic signed [31:0]         left_bound;
        logic signed [31:0]         right_bound;
        logic signed [31:0]         bottom_bound;
        logic signed [31:0]         top_bound;
        logic signed [31:0]         near_plane;
        logic signed [31:0]         far_plane;
        logic [FOV_W-1:0]           field_of_view;
        logic [ASPECT_W-1:0]        aspect_ratio;
    } ppm_in_t;

    typedef struct packed {
        logic [1:0]         column_index;
        logic signed [31:0] elem_a;
        logic signed [31:0] elem_b;
        logic signed [31:0] elem_c;
        logic signed [31:0] elem_d;
        logic               degenerate;
        logic               saturated;
        logic               last_beat;
    } ppm_out_t;

endpackage

// ----- rtl/core/ppm_cordic.sv -----
// Pipelined rotation-mode CORDIC, one micro-rotation per register stage.
// Depends on ppm_pkg for widths, gain and the arctangent table.
module ppm_cordic (
    input  logic            aclk,
    input  logic            en,
    input  ppm_pkg::cword_t z_in,
    output ppm_pkg::cword_t cos_out,
    output ppm_pkg::cword_t sin_out
);

    ppm_pkg::cword_t x_reg [ppm_pkg::CORDIC_STEPS];
    ppm_pkg::cword_t y_reg [ppm_pkg::CORDIC_STEPS];
    ppm_pkg::cword_t z_reg [ppm_pkg::CORDIC_STEPS];

    for (genvar i = 0; i < ppm_pkg::CORDIC_STEPS; i++) begin : g_step
        ppm_pkg::cword_t x_prev, y_prev, z_prev;
        if (i == 0) begin : g_first
            assign x_prev = ppm_pkg::cword_t'(ppm_pkg::CORDIC_GAIN_Q30);
            assign y_prev = '0;
            assign z_prev = z_in;
        end else begin : g_rest
            assign x_prev = x_reg[i-1];
            assign y_prev = y_reg[i-1];
            assign z_prev = z_reg[i-1];
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                if (!z_prev[ppm_pkg::CORDIC_W-1]) begin
                    x_reg[i] <= x_prev - (y_prev >>> i);
                    y_reg[i] <= y_prev + (x_prev >>> i);
                    z_reg[i] <= z_prev - ppm_pkg::ATAN_Q30[i];
                end else begin
                    x_reg[i] <= x_prev + (y_prev >>> i);
                    y_reg[i] <= y_prev - (x_prev >>> i);
                    z_reg[i] <= z_prev + ppm_pkg::ATAN_Q30[i];
                end
            end
        end
    end

    assign cos_out = x_reg[ppm_pkg::CORDIC_STEPS-1];
    assign sin_out = y_reg[ppm_pkg::CORDIC_STEPS-1];

endmodule

// ----- rtl/core/ppm_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, round half up.
// Depends on ppm_pkg for operand widths.
module ppm_div (
    input  logic                          aclk,
    input  logic                          en,
    input  logic [ppm_pkg::DIV_NUM_W-1:0] num,
    input  logic [ppm_pkg::DIV_DEN_W-1:0] den,
    output logic [ppm_pkg::DIV_Q_W-1:0]   quo
);

    localparam int NW = ppm_pkg::DIV_NUM_W;
    localparam int DW = ppm_pkg::DIV_DEN_W;

    logic [DW-1:0] rem_reg [NW+1];
    logic [NW-1:0] num_reg [NW+1];
    logic [NW-1:0] quo_reg [NW+1];
    logic [DW-1:0] den_reg [NW+1];
    logic [ppm_pkg::DIV_Q_W-1:0] quo_out_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= '0;
            num_reg[0] <= num;
            quo_reg[0] <= '0;
            den_reg[0] <= den;
        end
    end

    for (genvar i = 1; i <= NW; i++) begin : g_bit
        logic [DW:0] trial;
        logic        take;
        assign trial = {rem_reg[i-1], num_reg[i-1][NW-1]};
        assign take  = trial >= {1'b0, den_reg[i-1]};

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i] <= take ? DW'(trial - {1'b0, den_reg[i-1]}) : trial[DW-1:0];
                num_reg[i] <= {num_reg[i-1][NW-2:0], 1'b0};
                quo_reg[i] <= {quo_reg[i-1][NW-2:0], take};
                den_reg[i] <= den_reg[i-1];
            end
        end
    end

    // round to nearest: bump when twice the remainder reaches the divisor
    always_ff @(posedge aclk) begin
        if (en) begin
            quo_out_reg <= {1'b0, quo_reg[NW]} +
                ppm_pkg::DIV_Q_W'({rem_reg[NW], 1'b0} >= {1'b0, den_reg[NW]});
        end
    end

    assign quo = quo_out_reg;

endmodule

// ----- rtl/core/perspective_projection_matrix.sv -----
// Top level: builds a 4x4 Q16.16 projection matrix per request.
// Depends on ppm_pkg, ppm_cordic and ppm_div.
//
// Usage:
//   s_valid/s_ready/s_data carry one request per beat (frustum bounds, or
//   field of view and aspect in perspective mode). m_valid/m_ready/m_data
//   return four beats per request, column_index 0..3, last_beat on the
//   fourth. degenerate and saturated repeat on all four beats.
// Path: a 30-stage CORDIC for the tangent, a 66-stage divider for ymax,
//   then six parallel 66-stage dividers for the matrix terms, plus seven
//   single register stages.
// Flow: requests enter the pipeline back to back while it fills; the
//   four-beat output serializer sets the sustained request rate.
// Reset: aresetn low clears every stage valid and the output serializer and
//   holds s_ready low; no request is in flight afterwards.
// Stall: while the serializer holds a matrix whose last beat has not yet
//   been taken and the last stage is also full, the whole pipeline holds
//   and s_ready drops; nothing is lost or repeated.
module perspective_projection_matrix (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  ppm_pkg::ppm_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output ppm_pkg::ppm_out_t m_data
);

    localparam int F    = ppm_pkg::FRAC_BITS;
    localparam int NCS  = ppm_pkg::CORDIC_STEPS;
    localparam int DL   = ppm_pkg::DIV_LAT;
    localparam int QW   = ppm_pkg::DIV_Q_W;
    localparam int NW   = ppm_pkg::DIV_NUM_W;
    localparam int DW   = ppm_pkg::DIV_DEN_W;
    localparam int AW   = ppm_pkg::ASPECT_W;
    localparam int FW   = ppm_pkg::FOV_W;
    localparam int ZPW  = FW + 28;
    localparam int PW   = 31 + AW + 1;
    localparam logic [30:0]        MAX_POS = '1;
    localparam logic [FW-1:0]      FOV_LIM = FW'(180 << F);
    localparam logic signed [31:0] ONE     = 32'sd1 <<< F;

    typedef struct packed {
        logic               opcode;
        logic signed [31:0] l;
        logic signed [31:0] r;
        logic signed [31:0] b;
        logic signed [31:0] t;
        logic signed [31:0] n;
        logic signed [31:0] f;
        logic [AW-1:0]      aspect;
    } front_t;

    typedef struct packed {
        logic   neg;
        logic   cpos;
        front_t side;
    } mid_t;

    typedef struct packed {
        logic [5:0] neg;
        logic       degen;
        logic       sat;
    } tail_t;

    function automatic logic [32:0] pack_q(input logic neg, input logic [QW-1:0] mag);
        logic [QW-1:0] lim;
        logic [31:0]   m;
        lim = neg ? QW'(33'h080000000) : QW'(MAX_POS);
        m   = (mag > lim) ? lim[31:0] : mag[31:0];
        return {mag > lim, neg ? 32'(-m) : m};
    endfunction

    function automatic logic [32:0] mag33(input logic signed [32:0] v);
        return v[32] ? 33'(-v) : 33'(v);
    endfunction

    logic en, ser_load;

    // ---------------- input register
    ppm_pkg::ppm_in_t in_reg;
    logic             in_v_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_v_reg <= 1'b0;
        end else if (en) begin
            in_v_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            in_reg <= s_data;
        end
    end

    // ---------------- half angle in Q2.30 radians
    logic [FW-1:0]   fov_c;
    logic [ZPW-1:0]  z_prod;
    ppm_pkg::cword_t z_reg;
    front_t          s1_side_reg;
    logic            s1_v_reg;

    assign fov_c  = (in_reg.field_of_view > FOV_LIM) ? FOV_LIM : in_reg.field_of_view;
    assign z_prod = ZPW'(fov_c) * ZPW'(ppm_pkg::PI_OVER_360_Q32) + (ZPW'(1) << (F + 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_v_reg <= 1'b0;
        end else if (en) begin
            s1_v_reg <= in_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            z_reg       <= ppm_pkg::cword_t'(z_prod >> (F + 2));
            s1_side_reg <= '{opcode: in_reg.opcode, l: in_reg.left_bound,
                             r: in_reg.right_bound, b: in_reg.bottom_bound,
                             t: in_reg.top_bound, n: in_reg.near_plane,
                             f: in_reg.far_plane, aspect: in_reg.aspect_ratio};
        end
    end

    // ---------------- tangent parts
    ppm_pkg::cword_t cos_c, sin_c;
    front_t          cd_side_reg [NCS];
    logic [NCS-1:0]  cd_v_reg;

    ppm_cordic u_cordic (
        .aclk    (aclk),
        .en      (en),
        .z_in    (z_reg),
        .cos_out (cos_c),
        .sin_out (sin_c)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cd_v_reg <= '0;
        end else if (en) begin
            cd_v_reg <= {cd_v_reg[NCS-2:0], s1_v_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cd_side_reg[0] <= s1_side_reg;
            for (int i = 1; i < NCS; i++) begin
                cd_side_reg[i] <= cd_side_reg[i-1];
            end
        end
    end

    // ---------------- near * sin, ahead of the divide by cos
    front_t         cd_side;
    logic [31:0]    mag_n1;
    logic [32:0]    mag_s;
    logic [NW-1:0]  m1_prod_reg;
    logic [DW-1:0]  m1_den_reg;
    mid_t           m1_mid_reg;
    logic           m1_v_reg;

    assign cd_side = cd_side_reg[NCS-1];
    assign mag_n1  = cd_side.n[31] ? 32'(-cd_side.n) : 32'(cd_side.n);
    assign mag_s   = sin_c[ppm_pkg::CORDIC_W-1] ? 33'(-sin_c) : 33'(sin_c);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m1_v_reg <= 1'b0;
        end else if (en) begin
            m1_v_reg <= cd_v_reg[NCS-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m1_prod_reg <= NW'(65'(mag_n1) * 65'(mag_s));
            m1_den_reg  <= cos_c[DW-1:0];
            m1_mid_reg  <= '{neg: cd_side.n[31] ^ sin_c[ppm_pkg::CORDIC_W-1],
                             cpos: !cos_c[ppm_pkg::CORDIC_W-1] && (cos_c != '0),
                             side: cd_side};
        end
    end

    // ---------------- ymax divide
    logic [QW-1:0] q1;
    mid_t          d1_mid_reg [DL];
    logic [DL-1:0] d1_v_reg;

    ppm_div u_div_y (
        .aclk (aclk),
        .en   (en),
        .num  (m1_prod_reg),
        .den  (m1_den_reg),
        .quo  (q1)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d1_v_reg <= '0;
        end else if (en) begin
            d1_v_reg <= {d1_v_reg[DL-2:0], m1_v_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d1_mid_reg[0] <= m1_mid_reg;
            for (int i = 1; i < DL; i++) begin
                d1_mid_reg[i] <= d1_mid_reg[i-1];
            end
        end
    end

    // ---------------- ymax clamp
    mid_t               d1_mid;
    logic [30:0]        y_mag;
    logic signed [31:0] y_val;
    logic               y_sat;
    logic signed [31:0] y_ymax_reg;
    logic               y_sat_reg;
    front_t             y_side_reg;
    logic               y_v_reg;

    assign d1_mid = d1_mid_reg[DL-1];

    always_comb begin
        y_mag = (q1 > QW'(MAX_POS)) ? MAX_POS : q1[30:0];
        y_sat = 1'b0;
        y_val = '0;
        if (!d1_mid.cpos) begin
            // infinite tangent: clamp toward the sign of near
            if (d1_mid.side.n != '0) begin
                y_sat = 1'b1;
                y_val = d1_mid.side.n[31] ? -32'(MAX_POS) : 32'(MAX_POS);
            end
        end else begin
            y_sat = q1 > QW'(MAX_POS);
            y_val = d1_mid.neg ? -32'(y_mag) : 32'(y_mag);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            y_v_reg <= 1'b0;
        end else if (en) begin
            y_v_reg <= d1_v_reg[DL-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            y_ymax_reg <= y_val;
            y_sat_reg  <= y_sat;
            y_side_reg <= d1_mid.side;
        end
    end

    // ---------------- xmax and bound select
    logic signed [31:0] y_negv;
    logic [30:0]        mag_y;
    logic [PW-1:0]      p_full;
    logic [PW-1:0]      p_sh;
    logic               x_sat_c;
    logic [30:0]        x_mag;
    logic signed [31:0] xmax;
    logic signed [31:0] x_l_reg, x_r_reg, x_b_reg, x_t_reg, x_n_reg, x_f_reg;
    logic               x_sat_reg;
    logic               x_v_reg;

    assign y_negv  = -y_ymax_reg;
    assign mag_y   = y_ymax_reg[31] ? y_negv[30:0] : y_ymax_reg[30:0];
    assign p_full  = PW'(mag_y) * PW'(y_side_reg.aspect) + (PW'(1) << (F - 1));
    assign p_sh    = p_full >> F;
    assign x_sat_c = p_sh > PW'(MAX_POS);
    assign x_mag   = x_sat_c ? MAX_POS : p_sh[30:0];
    assign xmax    = y_ymax_reg[31] ? -32'(x_mag) : 32'(x_mag);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_v_reg <= 1'b0;
        end else if (en) begin
            x_v_reg <= y_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_n_reg <= y_side_reg.n;
            x_f_reg <= y_side_reg.f;
            if (y_side_reg.opcode) begin
                x_l_reg   <= -xmax;
                x_r_reg   <= xmax;
                x_b_reg   <= -y_ymax_reg;
                x_t_reg   <= y_ymax_reg;
                x_sat_reg <= y_sat_reg | x_sat_c;
            end else begin
                x_l_reg   <= y_side_reg.l;
                x_r_reg   <= y_side_reg.r;
                x_b_reg   <= y_side_reg.b;
                x_t_reg   <= y_side_reg.t;
                x_sat_reg <= 1'b0;
            end
        end
    end

    // ---------------- differences, sums, numerators
    logic signed [32:0] dx, dy, dz, sx, sy, sz;
    logic [32:0]        mdx, mdy, mdz, msx, msy, msz;
    logic [31:0]        mag_n2, mag_f2;
    logic [NW-1:0]      pre_num_reg [6];
    logic [DW-1:0]      pre_den_reg [6];
    tail_t              pre_tail_reg;
    logic               pre_v_reg;

    assign dx = {x_r_reg[31], x_r_reg} - {x_l_reg[31], x_l_reg};
    assign dy = {x_t_reg[31], x_t_reg} - {x_b_reg[31], x_b_reg};
    assign dz = {x_f_reg[31], x_f_reg} - {x_n_reg[31], x_n_reg};
    assign sx = {x_r_reg[31], x_r_reg} + {x_l_reg[31], x_l_reg};
    assign sy = {x_t_reg[31], x_t_reg} + {x_b_reg[31], x_b_reg};
    assign sz = {x_f_reg[31], x_f_reg} + {x_n_reg[31], x_n_reg};
    assign mdx = mag33(dx);
    assign mdy = mag33(dy);
    assign mdz = mag33(dz);
    assign msx = mag33(sx);
    assign msy = mag33(sy);
    assign msz = mag33(sz);
    assign mag_n2 = x_n_reg[31] ? 32'(-x_n_reg) : 32'(x_n_reg);
    assign mag_f2 = x_f_reg[31] ? 32'(-x_f_reg) : 32'(x_f_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pre_v_reg <= 1'b0;
        end else if (en) begin
            pre_v_reg <= x_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pre_num_reg[0] <= NW'({mag_n2, 1'b0}) << F;
            pre_num_reg[1] <= NW'({mag_n2, 1'b0}) << F;
            pre_num_reg[2] <= NW'(msx) << F;
            pre_num_reg[3] <= NW'(msy) << F;
            pre_num_reg[4] <= NW'(msz) << F;
            pre_num_reg[5] <= (NW'(mag_f2) * NW'(mag_n2)) << 1;
            pre_den_reg[0] <= mdx;
            pre_den_reg[1] <= mdy;
            pre_den_reg[2] <= mdx;
            pre_den_reg[3] <= mdy;
            pre_den_reg[4] <= mdz;
            pre_den_reg[5] <= mdz;
            pre_tail_reg.neg[0] <= x_n_reg[31] ^ dx[32];
            pre_tail_reg.neg[1] <= x_n_reg[31] ^ dy[32];
            pre_tail_reg.neg[2] <= sx[32] ^ dx[32];
            pre_tail_reg.neg[3] <= sy[32] ^ dy[32];
            pre_tail_reg.neg[4] <= !sz[32] ^ dz[32];
            pre_tail_reg.neg[5] <= !(x_f_reg[31] ^ x_n_reg[31]) ^ dz[32];
            pre_tail_reg.degen  <= (x_l_reg == x_r_reg) || (x_t_reg == x_b_reg) ||
                                   (x_n_reg == x_f_reg);
            pre_tail_reg.sat    <= x_sat_reg;
        end
    end

    // ---------------- six matrix term divides
    logic [QW-1:0] qm [6];
    tail_t         d2_tail_reg [DL];
    logic [DL-1:0] d2_v_reg;

    for (genvar k = 0; k < 6; k++) begin : g_term
        ppm_div u_div (
            .aclk (aclk),
            .en   (en),
            .num  (pre_num_reg[k]),
            .den  (pre_den_reg[k]),
            .quo  (qm[k])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d2_v_reg <= '0;
        end else if (en) begin
            d2_v_reg <= {d2_v_reg[DL-2:0], pre_v_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d2_tail_reg[0] <= pre_tail_reg;
            for (int i = 1; i < DL; i++) begin
                d2_tail_reg[i] <= d2_tail_reg[i-1];
            end
        end
    end

    // ---------------- pack into the matrix
    tail_t              d2_tail;
    logic [32:0]        pq [6];
    logic signed [31:0] pk_m_next [16];
    logic               pk_sat_next;
    logic signed [31:0] pk_m_reg [16];
    logic               pk_degen_reg, pk_sat_reg, pk_v_reg;

    assign d2_tail = d2_tail_reg[DL-1];

    for (genvar k = 0; k < 6; k++) begin : g_pack
        assign pq[k] = pack_q(d2_tail.neg[k], qm[k]);
    end

    always_comb begin
        for (int j = 0; j < 16; j++) begin
            pk_m_next[j] = '0;
        end
        if (d2_tail.degen) begin
            pk_m_next[0]  = ONE;
            pk_m_next[5]  = ONE;
            pk_m_next[10] = ONE;
            pk_m_next[15] = ONE;
            pk_sat_next   = 1'b0;
        end else begin
            pk_m_next[0]  = pq[0][31:0];
            pk_m_next[5]  = pq[1][31:0];
            pk_m_next[8]  = pq[2][31:0];
            pk_m_next[9]  = pq[3][31:0];
            pk_m_next[10] = pq[4][31:0];
            pk_m_next[11] = -ONE;
            pk_m_next[14] = pq[5][31:0];
            pk_sat_next   = d2_tail.sat | pq[0][32] | pq[1][32] | pq[2][32] |
                            pq[3][32] | pq[4][32] | pq[5][32];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pk_v_reg <= 1'b0;
        end else if (en) begin
            pk_v_reg <= d2_v_reg[DL-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pk_m_reg     <= pk_m_next;
            pk_degen_reg <= d2_tail.degen;
            pk_sat_reg   <= pk_sat_next;
        end
    end

    // ---------------- four-beat output serializer
    logic signed [31:0] ser_m_reg [16];
    logic               ser_degen_reg, ser_sat_reg;
    logic               busy_reg;
    logic [1:0]         beat_reg;
    logic [3:0]         base;

    // load when empty or when the last beat of the held matrix leaves
    assign ser_load = pk_v_reg && (!busy_reg || (m_ready && (beat_reg == 2'd3)));
    assign en       = !pk_v_reg || ser_load;
    assign s_ready  = en && aresetn;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            beat_reg <= '0;
        end else if (ser_load) begin
            busy_reg <= 1'b1;
            beat_reg <= '0;
        end else if (busy_reg && m_ready) begin
            if (beat_reg == 2'd3) begin
                busy_reg <= 1'b0;
            end
            beat_reg <= beat_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ser_load) begin
            ser_m_reg     <= pk_m_reg;
            ser_degen_reg <= pk_degen_reg;
            ser_sat_reg   <= pk_sat_reg;
        end
    end

    assign base    = {beat_reg, 2'b00};
    assign m_valid = busy_reg;

    always_comb begin
        m_data.column_index = beat_reg;
        m_data.elem_a       = ser_m_reg[base];
        m_data.elem_b       = ser_m_reg[base + 4'd1];
        m_data.elem_c       = ser_m_reg[base + 4'd2];
        m_data.elem_d       = ser_m_reg[base + 4'd3];
        m_data.degenerate   = ser_degen_reg;
        m_data.saturated    = ser_sat_reg;
        m_data.last_beat    = beat_reg == 2'd3;
    end

endmodule

// ----- test/tb_perspective_projection_matrix.sv -----
// Testbench for perspective_projection_matrix: directed and random requests in both
// modes, checked beat by beat against a fixed-point matrix predictor. Needs ppm_pkg.
module tb_perspective_projection_matrix;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic OP_FRUSTUM     = 1'b0;
    localparam logic OP_PERSPECTIVE = 1'b1;
    localparam int   IDLE_LIMIT     = 4000;
    localparam int   HOLD_OFF       = 700;
    localparam int   FB             = ppm_pkg::FRAC_BITS;
    localparam longint unsigned MAXP = 64'h7FFF_FFFF;
    localparam longint unsigned MAXN = 64'h8000_0000;

    class matrix_scoreboard;
        ppm_pkg::ppm_out_t beats_due[$];
        int       errors;
        int       requests;
        int       beats_seen;
        int       degen_seen;
        int       sat_seen;

        function longint unsigned mag(longint v);
            return v < 0 ? longint'(-v) : longint'(v);
        endfunction

        function longint unsigned div_round(longint unsigned n, longint unsigned d);
            longint unsigned q, r;
            q = n / d;
            r = n % d;
            if (r >= d - r) q++;
            return q;
        endfunction

        function longint clamp(bit neg, longint unsigned m, inout bit sat);
            if (!neg) begin
                if (m > MAXP) begin sat = 1; m = MAXP; end
                return longint'(m);
            end
            if (m > MAXN) begin sat = 1; m = MAXN; end
            return -longint'(m);
        endfunction

        function longint clamp_sym(bit neg, longint unsigned m, inout bit sat);
            if (m > MAXP) begin sat = 1; m = MAXP; end
            return neg ? -longint'(m) : longint'(m);
        endfunction

        function longint ratio(bit neg, longint unsigned n, longint d, inout bit sat);
            return clamp(neg != (d < 0), div_round(n, mag(d)), sat);
        endfunction

        // Rotate by half the field of view; returns sine and cosine in Q2.30.
        function void half_angle_tan(longint unsigned fov, output longint s, output longint c);
            longint x, y, z, nx;
            if (fov > (64'd180 << FB)) fov = 64'd180 << FB;
            x = ppm_pkg::CORDIC_GAIN_Q30;
            y = 0;
            z = longint'((fov * ppm_pkg::PI_OVER_360_Q32 + (64'd1 << (FB + 1))) >> (FB + 2));
            for (int i = 0; i < ppm_pkg::CORDIC_STEPS; i++) begin
                if (z >= 0) begin
                    nx = x - (y >>> i);
                    y  = y + (x >>> i);
                    z  = z - longint'(ppm_pkg::ATAN_Q30[i]);
                end else begin
                    nx = x + (y >>> i);
                    y  = y - (x >>> i);
                    z  = z + longint'(ppm_pkg::ATAN_Q30[i]);
                end
                x = nx;
            end
            s = y;
            c = x;
        endfunction

        function void note_request(ppm_pkg::ppm_in_t rq);
            longint l, r, b, t, n, f, s, c, ymax, xmax, m[16];
            longint unsigned p, twon;
            bit sat, degen;
            ppm_pkg::ppm_out_t o;
            sat = 0;
            n = longint'(rq.near_plane);
            f = longint'(rq.far_plane);
            if (rq.opcode == OP_PERSPECTIVE) begin
                half_angle_tan(rq.field_of_view, s, c);
                if (c <= 0) begin
                    if (n == 0) ymax = 0;
                    else begin
                        sat = 1;
                        ymax = n < 0 ? -longint'(MAXP) : longint'(MAXP);
                    end
                end else begin
                    ymax = clamp_sym((n < 0) != (s < 0), div_round(mag(n) * mag(s), c), sat);
                end
                p = (mag(ymax) * rq.aspect_ratio + (64'd1 << (FB - 1))) >> FB;
                xmax = clamp_sym(ymax < 0, p, sat);
                l = -xmax; r = xmax; b = -ymax; t = ymax;
            end else begin
                l = rq.left_bound;
                r = rq.right_bound;
                b = rq.bottom_bound;
                t = rq.top_bound;
            end
            foreach (m[j]) m[j] = 0;
            degen = (l == r) || (t == b) || (n == f);
            if (degen) begin
                sat = 0;
                m[0] = 1 << FB; m[5] = m[0]; m[10] = m[0]; m[15] = m[0];
            end else begin
                twon  = (mag(n) * 2) << FB;
                m[0]  = ratio(n < 0, twon, r - l, sat);
                m[5]  = ratio(n < 0, twon, t - b, sat);
                m[8]  = ratio((r + l) < 0, mag(r + l) << FB, r - l, sat);
                m[9]  = ratio((t + b) < 0, mag(t + b) << FB, t - b, sat);
                m[10] = ratio(!((f + n) < 0), mag(f + n) << FB, f - n, sat);
                m[11] = -(longint'(1) << FB);
                m[14] = ratio(!((f < 0) != (n < 0)), mag(f) * mag(n) * 2, f - n, sat);
            end
            requests++;
            if (degen) degen_seen++;
            if (sat) sat_seen++;
            for (int k = 0; k < 4; k++) begin
                o.column_index = 2'(k);
                o.elem_a       = m[4*k][31:0];
                o.elem_b       = m[4*k+1][31:0];
                o.elem_c       = m[4*k+2][31:0];
                o.elem_d       = m[4*k+3][31:0];
                o.degenerate   = degen;
                o.saturated    = sat;
                o.last_beat    = (k == 3);
                beats_due.push_back(o);
            end
        endfunction

        function void cmp(string name, longint e, longint a);
            if (e != a) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d (0x%0h), got %0d (0x%0h)",
                         $realtime, name, e, e, a, a);
            end
        endfunction

        function void check_beat(ppm_pkg::ppm_out_t got);
            ppm_pkg::ppm_out_t e;
            beats_seen++;
            if (beats_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected beat, expected none, got %h", $realtime, got);
                return;
            end
            e = beats_due.pop_front();
            cmp("column_index", e.column_index, got.column_index);
            cmp("elem_a", e.elem_a, got.elem_a);
            cmp("elem_b", e.elem_b, got.elem_b);
            cmp("elem_c", e.elem_c, got.elem_c);
            cmp("elem_d", e.elem_d, got.elem_d);
            cmp("degenerate", e.degenerate, got.degenerate);
            cmp("saturated", e.saturated, got.saturated);
            cmp("last_beat", e.last_beat, got.last_beat);
        endfunction
    endclass

    logic              aclk = 0;
    logic              aresetn = 0;
    logic              s_valid = 0;
    logic              s_ready;
    ppm_pkg::ppm_in_t  s_data = '0;
    logic              m_valid;
    logic              m_ready = 0;
    ppm_pkg::ppm_out_t m_data;

    matrix_scoreboard sb = new();
    ppm_pkg::ppm_in_t requests_q[$];
    int      idle_cycles = 0;
    bit      hold_done = 0;

    perspective_projection_matrix dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always begin
        #4 aclk = 1;
        #4 aclk = 0;
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("FAILURE");
            $finish;
        end
    end

    function automatic ppm_pkg::ppm_in_t make_req(logic op, longint l, longint r, longint b,
                                                  longint t, longint n, longint f,
                                                  longint fov, longint asp);
        ppm_pkg::ppm_in_t q;
        q.opcode        = op;
        q.left_bound    = l[31:0];
        q.right_bound   = r[31:0];
        q.bottom_bound  = b[31:0];
        q.top_bound     = t[31:0];
        q.near_plane    = n[31:0];
        q.far_plane     = f[31:0];
        q.field_of_view = fov[ppm_pkg::FOV_W-1:0];
        q.aspect_ratio  = asp[ppm_pkg::ASPECT_W-1:0];
        return q;
    endfunction

    function automatic logic signed [31:0] small_q();
        return $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
    endfunction

    task automatic send_requests();
        int gap;
        foreach (requests_q[i]) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
            if (gap > 0) begin
                s_valid <= 0;
                repeat (gap) @(posedge aclk);
            end
            s_valid <= 1;
            s_data  <= requests_q[i];
            do @(posedge aclk); while (!s_ready);
            sb.note_request(requests_q[i]);
        end
        s_valid <= 0;
    endtask

    task automatic drain_results();
        int stall;
        forever begin
            // Once, starve the output long enough to back up the whole pipeline.
            if (!hold_done && sb.beats_seen >= 60) begin
                hold_done = 1;
                m_ready <= 0;
                repeat (HOLD_OFF) @(posedge aclk);
            end
            stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 16);
            if (stall > 0) begin
                m_ready <= 0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1;
            do @(posedge aclk); while (!m_valid);
            sb.check_beat(m_data);
        end
    endtask

    initial begin
        longint one, n, f;
        one = 1 << FB;
        // Directed: ordinary, degenerate, saturating and special perspective cases.
        requests_q.push_back(make_req(OP_FRUSTUM, -one, one, -one, one, one, 100*one, 0, 0));
        requests_q.push_back(make_req(OP_FRUSTUM, one, one, -one, one, one, 10*one, 0, 0));
        requests_q.push_back(make_req(OP_FRUSTUM, -one, one, 2*one, 2*one, one, 10*one, 0, 0));
        requests_q.push_back(make_req(OP_FRUSTUM, -one, one, -one, one, 5*one, 5*one, 0, 0));
        requests_q.push_back(make_req(OP_FRUSTUM, -2147483648, 2147483647, -2147483648,
                                      2147483647, 2147483647, -2147483648, 0, 0));
        requests_q.push_back(make_req(OP_FRUSTUM, 2147483647, -2147483648, 2147483647,
                                      -2147483648, -2147483648, 2147483647, 0, 0));
        requests_q.push_back(make_req(OP_FRUSTUM, 0, 1, 0, 1, 2147483647, 0, 0, 0));
        requests_q.push_back(make_req(OP_FRUSTUM, -3*one, one, 2*one, -one, -one, -7*one,
                                      24'hFFFFFF, 31'h7FFFFFFF));
        requests_q.push_back(make_req(OP_PERSPECTIVE, 0, 0, 0, 0, one/10, 100*one, 60*one, one));
        requests_q.push_back(make_req(OP_PERSPECTIVE, 0, 0, 0, 0, one, 50*one, 90*one,
                                      (16*one)/9));
        requests_q.push_back(make_req(OP_PERSPECTIVE, 0, 0, 0, 0, one, 50*one, 0, one));
        requests_q.push_back(make_req(OP_PERSPECTIVE, 0, 0, 0, 0, one, 50*one, 180*one, one));
        requests_q.push_back(make_req(OP_PERSPECTIVE, 0, 0, 0, 0, -one, 50*one, 180*one, one));
        requests_q.push_back(make_req(OP_PERSPECTIVE, 0, 0, 0, 0, 0, 50*one, 180*one, one));
        requests_q.push_back(make_req(OP_PERSPECTIVE, 0, 0, 0, 0, one, 9*one, 24'hFFFFFF, one));
        requests_q.push_back(make_req(OP_PERSPECTIVE, 0, 0, 0, 0, one, 9*one, 45*one, 0));
        requests_q.push_back(make_req(OP_PERSPECTIVE, 0, 0, 0, 0, one, 9*one, 45*one,
                                      31'h7FFFFFFF));
        requests_q.push_back(make_req(OP_PERSPECTIVE, -1, -1, -1, -1, 2147483647, 0,
                                      179*one, 2*one));
        requests_q.push_back(make_req(OP_PERSPECTIVE, 0, 0, 0, 0, -2147483648, 2147483647,
                                      170*one, 31'h7FFFFFFF));
        requests_q.push_back(make_req(OP_PERSPECTIVE, 0, 0, 0, 0, 3*one, 3*one, 70*one, one));
        // Random: mostly plausible setups, some full-range noise.
        repeat (140) begin
            ppm_pkg::ppm_in_t q;
            case ($urandom_range(0, 3))
                0: begin
                    n = $urandom_range(1, 20*one);
                    f = n + $urandom_range(0, 1000*one);
                    q = make_req(OP_FRUSTUM, small_q(), small_q(), small_q(), small_q(),
                                 n, f, $urandom, $urandom);
                end
                1, 2: begin
                    n = $urandom_range(1, 20*one);
                    f = $urandom_range(0, 3) == 0 ? n : n + $urandom_range(1, 1000*one);
                    q = make_req(OP_PERSPECTIVE, $urandom, $urandom, $urandom, $urandom, n, f,
                                 $urandom_range(0, 180*one), $urandom_range(0, 4*one));
                end
                default: begin
                    q = make_req($urandom_range(0, 1), $urandom, $urandom, $urandom, $urandom,
                                 $urandom, $urandom, $urandom, $urandom);
                    q.near_plane = $signed($urandom);
                    q.far_plane  = $signed($urandom);
                end
            endcase
            requests_q.push_back(q);
        end

        repeat (7) @(posedge aclk);
        aresetn <= 1;
        fork
            drain_results();
        join_none
        send_requests();
        while (sb.beats_due.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);

        $display("%0d requests, %0d beats checked (%0d degenerate, %0d saturated matrices)",
                 sb.requests, sb.beats_seen, sb.degen_seen, sb.sat_seen);
        if (sb.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches", sb.errors);
            $display("FAILURE");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
rtl/core/ppm_pkg.sv
rtl/core/ppm_cordic.sv
rtl/core/ppm_div.sv
rtl/core/perspective_projection_matrix.sv
test/tb_perspective_projection_matrix.sv
